// ===== hdl/lra_pkg.sv =====
`timescale 1ns / 1ps
// Shared types and constants of the linear ramp animator.
// Depends on nothing; imported by the controller, datapath and top level.
package lra_pkg;

  localparam int LEVEL_BITS_DEF = 16;
  localparam int TIME_BITS_DEF = 20;

  typedef enum logic [1:0] {
    ACT_TICK = 2'd0,
    ACT_REACH = 2'd1,
    ACT_INIT = 2'd2,
    ACT_SET_START = 2'd3
  } action_t;

  typedef enum logic [1:0] {
    MODE_QUIET = 2'd0,
    MODE_UP = 2'd1,
    MODE_DOWN = 2'd2
  } mode_t;

  typedef enum logic [2:0] {
    ST_IDLE,
    ST_EXEC,
    ST_DIV,
    ST_UPD,
    ST_OUT
  } state_t;

  typedef struct packed {
    logic take;
    logic apply;
    logic snap;
    logic mul;
    logic div_step;
    logic update;
    logic load_out;
  } lra_cmd_t;

  typedef struct packed {
    action_t act;
    logic ramping;
    logic past_end;
    logic div_last;
    logic out_free;
  } lra_status_t;

endpackage

// ===== hdl/lra_ctrl.sv =====
`timescale 1ns / 1ps
// Controller state machine of the linear ramp animator.
// Depends on lra_pkg; drives the datapath through lra_cmd_t commands.
module lra_ctrl
  import lra_pkg::*;
(
  input  logic        clk,
  input  logic        rst,
  input  logic        in_valid,
  output logic        in_ready,
  input  lra_status_t status,
  output lra_cmd_t    cmd
);

  state_t state;
  state_t state_next;

  always_ff @(posedge clk) begin
    if (rst) begin
      state <= ST_IDLE;
    end else begin
      state <= state_next;
    end
  end

  always_comb begin
    state_next = state;
    unique case (state)
      ST_IDLE: begin
        if (in_valid) begin
          state_next = ST_EXEC;
        end
      end
      ST_EXEC: begin
        if (status.act == ACT_TICK && status.ramping && !status.past_end) begin
          state_next = ST_DIV;
        end else begin
          state_next = ST_OUT;
        end
      end
      ST_DIV: begin
        if (status.div_last) begin
          state_next = ST_UPD;
        end
      end
      ST_UPD: begin
        state_next = ST_OUT;
      end
      ST_OUT: begin
        if (status.out_free) begin
          state_next = ST_IDLE;
        end
      end
      default: begin
        state_next = ST_IDLE;
      end
    endcase
  end

  always_comb begin
    cmd = '0;
    in_ready = 1'b0;
    unique case (state)
      ST_IDLE: begin
        in_ready = !rst;
        cmd.take = in_valid && !rst;
      end
      ST_EXEC: begin
        if (status.act != ACT_TICK) begin
          cmd.apply = 1'b1;
        end else if (status.ramping) begin
          if (status.past_end) begin
            cmd.snap = 1'b1;
          end else begin
            cmd.mul = 1'b1;
          end
        end
      end
      ST_DIV: begin
        cmd.div_step = 1'b1;
      end
      ST_UPD: begin
        cmd.update = 1'b1;
      end
      ST_OUT: begin
        cmd.load_out = status.out_free;
      end
      default: begin
        cmd = '0;
      end
    endcase
  end

`ifndef SYNTHESIS
  a_div_runs_on_tick: assert property (@(posedge clk) disable iff (rst)
    state == ST_DIV |-> $past(state) == ST_EXEC || $past(state) == ST_DIV)
    else $error("divider running outside a tick");
  a_one_beat_per_item: assert property (@(posedge clk) disable iff (rst)
    cmd.load_out |=> state == ST_IDLE)
    else $error("result loaded without returning to idle");
  a_take_only_idle: assert property (@(posedge clk) disable iff (rst)
    cmd.take |=> state == ST_EXEC)
    else $error("accepted beat not executed");
`endif

endmodule

// ===== hdl/lra_dp.sv =====
`timescale 1ns / 1ps
// Datapath of the linear ramp animator: ramp state, multiplier, serial divider
// and the output register. Depends on lra_pkg; commanded by lra_ctrl.
module lra_dp
  import lra_pkg::*;
#(
  parameter int LEVEL_BITS = LEVEL_BITS_DEF,
  parameter int TIME_BITS = TIME_BITS_DEF
) (
  input  logic                  clk,
  input  logic                  rst,
  input  lra_cmd_t              cmd,
  output lra_status_t           status,
  input  action_t               in_action,
  input  logic [LEVEL_BITS-1:0] in_level,
  input  logic [TIME_BITS-1:0]  in_duration,
  output logic                  out_valid,
  input  logic                  out_ready,
  output logic [LEVEL_BITS-1:0] out_level,
  output mode_t                 out_mode
);

  localparam int PROD_W = LEVEL_BITS + TIME_BITS;
  localparam int CNT_W = $clog2(LEVEL_BITS);

  action_t               act;
  logic [LEVEL_BITS-1:0] lvl_q;
  logic [TIME_BITS-1:0]  dur_q;

  logic [LEVEL_BITS-1:0] level;
  logic [LEVEL_BITS-1:0] ramp_start;
  logic [LEVEL_BITS-1:0] ramp_target;
  logic [TIME_BITS-1:0]  ramp_duration;
  logic [TIME_BITS-1:0]  elapsed_ms;
  mode_t                 mode;

  logic [PROD_W-1:0]     work;
  logic [CNT_W-1:0]      cnt;

  logic [TIME_BITS:0]    e_full;
  logic [TIME_BITS-1:0]  e_t;
  logic                  rising;
  logic [LEVEL_BITS-1:0] span;
  logic [PROD_W-1:0]     product;
  logic [TIME_BITS:0]    shifted;
  logic [TIME_BITS:0]    diff;
  logic                  ge;
  logic [LEVEL_BITS-1:0] step;
  logic [LEVEL_BITS-1:0] cand;
  logic                  overshoot;

  assign e_full = {1'b0, elapsed_ms} + {{TIME_BITS{1'b0}}, 1'b1};
  assign e_t = e_full[TIME_BITS-1:0];
  assign rising = ramp_target >= ramp_start;
  assign span = rising ? ramp_target - ramp_start : ramp_start - ramp_target;
  assign product = PROD_W'(span) * PROD_W'(e_t);

  assign shifted = {work[PROD_W-1:LEVEL_BITS], work[LEVEL_BITS-1]};
  assign diff = shifted - {1'b0, ramp_duration};
  assign ge = shifted >= {1'b0, ramp_duration};

  assign step = work[LEVEL_BITS-1:0];
  assign cand = rising ? ramp_start + step : ramp_start - step;
  assign overshoot = (mode == MODE_UP && cand > ramp_target) ||
                     (mode == MODE_DOWN && cand < ramp_target);

  assign status.act = act;
  assign status.ramping = mode == MODE_UP || mode == MODE_DOWN;
  assign status.past_end = e_full > {1'b0, ramp_duration};
  assign status.div_last = cnt == CNT_W'(LEVEL_BITS - 1);
  assign status.out_free = !out_valid || out_ready;

  always_ff @(posedge clk) begin
    if (cmd.take) begin
      act <= in_action;
      lvl_q <= in_level;
      dur_q <= in_duration;
    end
    if (cmd.mul) begin
      work <= product;
      cnt <= '0;
    end else if (cmd.div_step) begin
      work <= {ge ? diff[TIME_BITS-1:0] : shifted[TIME_BITS-1:0],
               work[LEVEL_BITS-2:0], ge};
      cnt <= cnt + 1'b1;
    end
    if (cmd.load_out) begin
      out_level <= level;
      out_mode <= mode;
    end
  end

  always_ff @(posedge clk) begin
    if (rst) begin
      level <= '0;
      ramp_start <= '0;
      ramp_target <= '1;
      ramp_duration <= '0;
      elapsed_ms <= '0;
      mode <= MODE_QUIET;
    end else if (cmd.apply) begin
      unique case (act)
        ACT_REACH: begin
          ramp_target <= lvl_q;
          ramp_duration <= dur_q;
          elapsed_ms <= '0;
          if (dur_q == '0) begin
            level <= lvl_q;
            ramp_start <= lvl_q;
            mode <= MODE_QUIET;
          end else begin
            ramp_start <= level;
            if (lvl_q > level) begin
              mode <= MODE_UP;
            end else if (lvl_q < level) begin
              mode <= MODE_DOWN;
            end else begin
              mode <= MODE_QUIET;
            end
          end
        end
        ACT_INIT: begin
          level <= lvl_q;
          ramp_start <= lvl_q;
          ramp_target <= '1;
          mode <= MODE_QUIET;
        end
        ACT_SET_START: begin
          level <= lvl_q;
          ramp_start <= lvl_q;
        end
        default: begin
          level <= level;
        end
      endcase
    end else if (cmd.snap || (cmd.update && overshoot)) begin
      level <= ramp_target;
      ramp_start <= ramp_target;
      mode <= MODE_QUIET;
    end else if (cmd.update) begin
      level <= cand;
      elapsed_ms <= e_t;
    end
  end

  always_ff @(posedge clk) begin
    if (rst) begin
      out_valid <= 1'b0;
    end else if (cmd.load_out) begin
      out_valid <= 1'b1;
    end else if (out_ready) begin
      out_valid <= 1'b0;
    end
  end

`ifndef SYNTHESIS
  a_elapsed_bound: assert property (@(posedge clk) disable iff (rst)
    elapsed_ms <= ramp_duration)
    else $error("elapsed count beyond ramp duration");
  a_step_in_span: assert property (@(posedge clk) disable iff (rst)
    cmd.update |-> step <= span)
    else $error("ramp step exceeds span");
  a_snap_lands: assert property (@(posedge clk) disable iff (rst)
    cmd.snap |=> mode == MODE_QUIET && level == ramp_target)
    else $error("snap did not land on target");
  a_mul_when_ramping: assert property (@(posedge clk) disable iff (rst)
    cmd.mul |-> status.ramping && !status.past_end)
    else $error("ramp arithmetic started while quiet or past end");
`endif

endmodule

// ===== hdl/linear_ramp_animator.sv =====
`timescale 1ns / 1ps
// Linear ramp animator: input and result streams, controller and datapath.
// Depends on lra_pkg, lra_ctrl and lra_dp.
//
// Input beats arrive on s_*: tuser carries the action (tick, reach, init,
// set start), tdata the level and duration. Every input beat yields exactly
// one result beat on m_* with the level and ramp state after that action.
// Reach, init, set start and ticks while quiet or at the ramp end are
// executed and then loaded into the result register. A tick during a ramp
// runs a multiply and a restoring divider that retires one quotient bit per
// cycle, then updates the level before its result is loaded. One beat is in
// work at a time; the next can be taken in the cycle after the result
// register is loaded. The result register holds its beat while m_tready
// is low and the block waits with s_tready low until it can load the next
// result. Reset gives level 0, start 0, target full scale, duration and
// elapsed count 0, and the quiet state, with no result pending; s_tready
// is held low while rst is high.
module linear_ramp_animator
  import lra_pkg::*;
#(
  parameter int LEVEL_BITS = LEVEL_BITS_DEF,
  parameter int TIME_BITS = TIME_BITS_DEF
) (
  input  logic clk,
  input  logic rst,
  input  logic s_tvalid,
  output logic s_tready,
  // level_in, duration_ms
  input  logic [((LEVEL_BITS + TIME_BITS + 7) / 8) * 8 - 1:0] s_tdata,
  // action
  input  logic [1:0] s_tuser,
  output logic m_tvalid,
  input  logic m_tready,
  // level_out, ramp_state
  output logic [((LEVEL_BITS + 2 + 7) / 8) * 8 - 1:0] m_tdata
);

  localparam int OUT_W = ((LEVEL_BITS + 2 + 7) / 8) * 8;

  lra_cmd_t              cmd;
  lra_status_t           status;
  logic [LEVEL_BITS-1:0] out_level;
  mode_t                 out_mode;

  lra_ctrl u_ctrl (
    .clk      (clk),
    .rst      (rst),
    .in_valid (s_tvalid),
    .in_ready (s_tready),
    .status   (status),
    .cmd      (cmd)
  );

  lra_dp #(
    .LEVEL_BITS (LEVEL_BITS),
    .TIME_BITS  (TIME_BITS)
  ) u_dp (
    .clk         (clk),
    .rst         (rst),
    .cmd         (cmd),
    .status      (status),
    .in_action   (action_t'(s_tuser)),
    .in_level    (s_tdata[LEVEL_BITS-1:0]),
    .in_duration (s_tdata[LEVEL_BITS+TIME_BITS-1:LEVEL_BITS]),
    .out_valid   (m_tvalid),
    .out_ready   (m_tready),
    .out_level   (out_level),
    .out_mode    (out_mode)
  );

  assign m_tdata = OUT_W'({out_mode, out_level});

endmodule
